[sv/sdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sdc_pkg;

    localparam int unsigned SDC_SIEVE_SIZE = 65536;

    localparam int NUM_W   = 16;                    // input number width
    localparam int PRIME_W = 8;                     // trial divisor width (p*p <= number)
    localparam int CNT_W   = 8;                     // divisor count width
    localparam int EXP_W   = 5;                     // exponent, at most 15
    localparam int STEP_W  = $clog2(NUM_W + 1);     // divider step counter

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   dividend;
        logic [PRIME_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic             rem_zero;
    } div_res_t;

endpackage
`default_nettype wire

[sv/sdc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. done pulses high for a single cycle once
// the last step is registered, and the result holds until the next start.
module sdc_div
    import sdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [PRIME_W-1:0] rem_reg;
    logic [PRIME_W-1:0] d_reg;

    logic [PRIME_W:0]   trial;
    logic [PRIME_W:0]   diff;
    logic               ge;
    logic [PRIME_W-1:0] rem_next;
    logic [NUM_W-1:0]   quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, d_reg};
        ge       = trial >= {1'b0, d_reg};
        // on a failed trial the top bit is zero since trial < divisor
        rem_next = ge ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            d_reg   <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign res.done     = done_reg;
    assign res.quot     = quo_reg;
    assign res.rem_zero = (rem_reg == '0);

endmodule
`default_nettype wire

[sv/sieve_divisor_counter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Signals                                            Beat
// -------  -------------------------------------------------  ----------------------------
// in       in_valid, in_stall, number                         number to factor
// out      out_valid, out_stall, divisor_count, out_of_range  divisor count and range flag
//
// After reset a fill pass clears flags 0 and 1 and sets the rest, then the sieve reads the flag
// of each candidate below sqrt(SIEVE_SIZE) and clears the multiples of each prime from its square;
// in_stall stays high until the flags are done. A query reads the flag of each candidate tested
// and runs each trial division on the 16-step divider; an out-of-range number skips straight to
// the result. One item at a time; the next is taken once the result sits in the output register,
// even if out_stall holds it there.
module sieve_divisor_counter_core
    import sdc_pkg::*;
#(
    parameter int unsigned SIEVE_SIZE = SDC_SIEVE_SIZE
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [NUM_W-1:0] number,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CNT_W-1:0] divisor_count,
    output logic             out_of_range
);

    localparam int AW = $clog2(SIEVE_SIZE);
    localparam int BW = AW + 1;
    localparam logic [BW-1:0] SIZE_B = BW'(SIEVE_SIZE);

    typedef enum logic [8:0] {
        ST_FILL  = 9'b000000001,
        ST_BREAD = 9'b000000010,
        ST_BFLAG = 9'b000000100,
        ST_BCLR  = 9'b000001000,
        ST_IDLE  = 9'b000010000,
        ST_QREAD = 9'b000100000,
        ST_QFLAG = 9'b001000000,
        ST_QDIV  = 9'b010000000,
        ST_QDONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // sieve build
    logic [AW-1:0] bp_reg,  bp_next;
    logic [BW-1:0] bsq_reg, bsq_next;
    logic [BW-1:0] bm_reg,  bm_next;
    // query
    logic [NUM_W-1:0] n_reg,     n_next;
    logic [NUM_W-1:0] qp_reg,    qp_next;
    logic [NUM_W:0]   qsq_reg,   qsq_next;
    logic [EXP_W-1:0] e_reg,     e_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic             oor_reg,   oor_next;
    // output register
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_cnt_reg,   out_cnt_next;
    logic             out_oor_reg,   out_oor_next;

    // flag memory
    logic          flag_mem [SIEVE_SIZE];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata_reg;

    div_req_t div_req;
    div_res_t div_res;

    logic [CNT_W+EXP_W-1:0] prod;
    logic [CNT_W-1:0]       prod_sat;
    logic [CNT_W-1:0]       dbl_sat;
    logic [BW-1:0]          bm_step;
    logic                   out_free;

    sdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flag_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= flag_mem[mem_raddr];
    end

    always_comb
    begin
        prod     = (CNT_W+EXP_W)'(total_reg) * (CNT_W+EXP_W)'(e_reg + 1'b1);
        prod_sat = (|prod[CNT_W+EXP_W-1:CNT_W]) ? '1 : prod[CNT_W-1:0];
        dbl_sat  = total_reg[CNT_W-1] ? '1 : {total_reg[CNT_W-2:0], 1'b0};
        bm_step  = bm_reg + BW'(bp_reg);
        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        bp_next        = bp_reg;
        bsq_next       = bsq_reg;
        bm_next        = bm_reg;
        n_next         = n_reg;
        qp_next        = qp_reg;
        qsq_next       = qsq_reg;
        e_next         = e_reg;
        total_next     = total_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_cnt_next   = out_cnt_reg;
        out_oor_next   = out_oor_reg;

        mem_we    = 1'b0;
        mem_waddr = bm_reg[AW-1:0];
        mem_wdata = 1'b0;
        mem_raddr = (state_reg == ST_QREAD) ? AW'(qp_reg) : bp_reg;

        div_req.start    = 1'b0;
        div_req.dividend = (state_reg == ST_QDIV) ? div_res.quot : n_reg;
        div_req.divisor  = qp_reg[PRIME_W-1:0];

        case (state_reg)
            ST_FILL:
            begin
                // 0 and 1 are not prime, everything else starts flagged
                mem_we    = 1'b1;
                mem_wdata = (bm_reg >= BW'(2));
                bm_next   = bm_reg + 1'b1;
                if (bm_reg == SIZE_B - 1'b1)
                begin
                    bp_next    = AW'(2);
                    bsq_next   = BW'(4);
                    state_next = ST_BREAD;
                end
            end
            ST_BREAD:
            begin
                if (bsq_reg >= SIZE_B)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BFLAG;
                end
            end
            ST_BFLAG:
            begin
                if (mem_rdata_reg)
                begin
                    bm_next    = bsq_reg;
                    state_next = ST_BCLR;
                end
                else
                begin
                    bp_next    = bp_reg + 1'b1;
                    bsq_next   = bsq_reg + {bp_reg, 1'b0} + 1'b1;
                    state_next = ST_BREAD;
                end
            end
            ST_BCLR:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                if (bm_step >= SIZE_B)
                begin
                    bp_next    = bp_reg + 1'b1;
                    bsq_next   = bsq_reg + {bp_reg, 1'b0} + 1'b1;
                    state_next = ST_BREAD;
                end
                else
                begin
                    bm_next = bm_step;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = number;
                    qp_next    = NUM_W'(2);
                    qsq_next   = (NUM_W+1)'(4);
                    e_next     = '0;
                    if (32'(number) >= 32'(SIEVE_SIZE))
                    begin
                        total_next = '0;
                        oor_next   = 1'b1;
                        state_next = ST_QDONE;
                    end
                    else
                    begin
                        total_next = CNT_W'(1);
                        oor_next   = 1'b0;
                        state_next = ST_QREAD;
                    end
                end
            end
            ST_QREAD:
            begin
                if (qp_reg > n_reg)
                begin
                    state_next = ST_QDONE;
                end
                else
                begin
                    state_next = ST_QFLAG;
                end
            end
            ST_QFLAG:
            begin
                if (!mem_rdata_reg)
                begin
                    qp_next    = qp_reg + 1'b1;
                    qsq_next   = qsq_reg + {qp_reg, 1'b0} + 1'b1;
                    state_next = ST_QREAD;
                end
                else if (qsq_reg > {1'b0, n_reg})
                begin
                    // what is left is 1 or a single prime
                    if (n_reg > NUM_W'(1))
                    begin
                        total_next = dbl_sat;
                    end
                    state_next = ST_QDONE;
                end
                else
                begin
                    e_next        = '0;
                    div_req.start = 1'b1;
                    state_next    = ST_QDIV;
                end
            end
            ST_QDIV:
            begin
                if (div_res.done)
                begin
                    if (div_res.rem_zero)
                    begin
                        n_next        = div_res.quot;
                        e_next        = e_reg + 1'b1;
                        div_req.start = 1'b1;
                    end
                    else
                    begin
                        total_next = prod_sat;
                        qp_next    = qp_reg + 1'b1;
                        qsq_next   = qsq_reg + {qp_reg, 1'b0} + 1'b1;
                        state_next = ST_QREAD;
                    end
                end
            end
            ST_QDONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = total_reg;
                    out_oor_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            bm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bm_reg        <= bm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg      <= bp_next;
        bsq_reg     <= bsq_next;
        n_reg       <= n_next;
        qp_reg      <= qp_next;
        qsq_reg     <= qsq_next;
        e_reg       <= e_next;
        total_reg   <= total_next;
        oor_reg     <= oor_next;
        out_cnt_reg <= out_cnt_next;
        out_oor_reg <= out_oor_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign divisor_count = out_cnt_reg;
    assign out_of_range  = out_oor_reg;

endmodule
`default_nettype wire
